// ----- rtl/iqm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqm_pkg
// Shared types and constants of the interquartile mean image filter.
// ----------------------------------------------------------------------------
package iqm_pkg;

    localparam logic ACT_PIXEL  = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SORT,
        ST_SUM,
        ST_DIV,
        ST_HOLD
    } iqm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic done_last;
    } iqm_bstat_t;

endpackage

// ----- rtl/iqm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqm_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- rtl/iqm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqm_fifo
// Two-entry job queue between the front end and the filter back end.
// ----------------------------------------------------------------------------
module iqm_fifo #(
    parameter int WIDTH = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic [1:0]       count
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign head_data = entry_reg[rptr_reg];
    assign count     = count_reg;

endmodule

// ----- rtl/iqm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqm_front
// Config registers, raster counters, line store writes and job issue.
// ----------------------------------------------------------------------------
module iqm_front import iqm_pkg::*; #(
    parameter int RADIUS    = 1,
    parameter int MAX_WIDTH = 1024,
    localparam int RING     = 3 * RADIUS + 1,
    localparam int RB       = $clog2(RING),
    localparam int XW       = $clog2(MAX_WIDTH),
    localparam int WW       = $clog2(MAX_WIDTH + 1),
    localparam int AW       = $clog2(RING * MAX_WIDTH),
    localparam int CW       = $clog2(MAX_WIDTH) + 12,
    localparam int JW       = 11 + XW + RB + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [10:0]   cfg_wdata,
    input  logic          acc,
    input  logic          action,
    input  logic [7:0]    pixel,
    input  iqm_bstat_t    bstat,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          job_push,
    output logic [JW-1:0] job_data,
    output logic [WW-1:0] w_eff,
    output logic [10:0]   h_eff,
    output logic          last_pend
);

    logic [10:0]   width_reg;
    logic [10:0]   height_reg;
    logic [CW-1:0] cnt_reg;
    logic [XW-1:0] wcol_reg;
    logic [RB-1:0] wring_reg;
    logic [XW-1:0] ocol_reg;
    logic [10:0]   orow_reg;
    logic [RB-1:0] oring_reg;
    logic          last_pend_reg;

    logic [31:0]   w_ext;
    logic [CW-1:0] total;
    logic [CW-1:0] lag;
    logic [XW-1:0] col_max;
    logic [10:0]   row_max;
    logic          in_frame;
    logic          drop;
    logic          produce;
    logic          is_last;

    always_comb
    begin
        w_ext = 32'(width_reg);
        if (w_ext == 32'd0)
        begin
            w_eff = WW'(1);
        end
        else if (w_ext > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_ext);
        end
    end

    assign h_eff    = (height_reg == 11'd0) ? 11'd1 : height_reg;
    assign total    = CW'(w_eff) * CW'(h_eff);
    assign lag      = CW'(RADIUS) * CW'(w_eff) + CW'(RADIUS);
    assign col_max  = XW'(w_eff - WW'(1));
    assign row_max  = h_eff - 11'd1;

    // a drain tick is only meaningful once the whole frame has arrived
    assign in_frame = cnt_reg < total;
    assign drop     = in_frame && (action == ACT_DRAIN);
    assign produce  = acc && !drop && (cnt_reg >= lag);
    assign is_last  = (orow_reg == row_max) && (ocol_reg == col_max);

    assign ram_we    = acc && in_frame && (action == ACT_PIXEL);
    assign ram_waddr = AW'(wring_reg) * AW'(MAX_WIDTH) + AW'(wcol_reg);
    assign ram_wdata = pixel;
    assign job_push  = produce;
    assign job_data  = {is_last, oring_reg, ocol_reg, orow_reg};
    assign last_pend = last_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'd256;
            height_reg    <= 11'd256;
            cnt_reg       <= '0;
            wcol_reg      <= '0;
            wring_reg     <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            oring_reg     <= '0;
            last_pend_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            else
            begin
                height_reg <= cfg_wdata;
            end
            cnt_reg   <= '0;
            wcol_reg  <= '0;
            wring_reg <= '0;
            ocol_reg  <= '0;
            orow_reg  <= '0;
            oring_reg <= '0;
        end
        else
        begin
            if (bstat.done_last)
            begin
                last_pend_reg <= 1'b0;
            end
            if (ram_we)
            begin
                if (wcol_reg == col_max)
                begin
                    wcol_reg  <= '0;
                    wring_reg <= (wring_reg == RB'(RING - 1)) ? '0 : wring_reg + RB'(1);
                end
                else
                begin
                    wcol_reg <= wcol_reg + XW'(1);
                end
            end
            if (produce)
            begin
                if (ocol_reg == col_max)
                begin
                    ocol_reg  <= '0;
                    orow_reg  <= orow_reg + 11'd1;
                    oring_reg <= (oring_reg == RB'(RING - 1)) ? '0 : oring_reg + RB'(1);
                end
                else
                begin
                    ocol_reg <= ocol_reg + XW'(1);
                end
            end
            if (produce && is_last)
            begin
                // frame done: every counter restarts for the next frame
                cnt_reg       <= '0;
                wcol_reg      <= '0;
                wring_reg     <= '0;
                ocol_reg      <= '0;
                orow_reg      <= '0;
                oring_reg     <= '0;
                last_pend_reg <= 1'b1;
            end
            else if (acc && !drop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

endmodule

// ----- rtl/iqm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqm_back
// Window fetch, transposition sort, trimmed sum, serial divide, output stage.
// ----------------------------------------------------------------------------
module iqm_back import iqm_pkg::*; #(
    parameter int RADIUS    = 1,
    parameter int MAX_WIDTH = 1024,
    localparam int RING     = 3 * RADIUS + 1,
    localparam int RB       = $clog2(RING),
    localparam int XW       = $clog2(MAX_WIDTH),
    localparam int WW       = $clog2(MAX_WIDTH + 1),
    localparam int AW       = $clog2(RING * MAX_WIDTH),
    localparam int JW       = 11 + XW + RB + 1,
    localparam int SPAN     = 2 * RADIUS + 1,
    localparam int CELLS    = SPAN * SPAN,
    localparam int SB       = $clog2(SPAN),
    localparam int CI       = $clog2(CELLS + 1),
    localparam int CIX      = $clog2(CELLS),
    localparam int SW       = $clog2(CELLS * 254 + 1),
    localparam int DB       = $clog2(SW + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  logic [JW-1:0] job_data,
    input  logic [WW-1:0] w_eff,
    input  logic [10:0]   h_eff,
    input  logic [7:0]    ram_rdata,
    input  logic          m_tready,
    output logic          job_pop,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    output logic          m_tvalid,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output iqm_bstat_t    bstat
);

    iqm_state_t    state_reg;
    iqm_state_t    state_next;

    logic [10:0]   row_reg;
    logic [XW-1:0] col_reg;
    logic [RB-1:0] ring_reg;
    logic          last_reg;
    logic [CI-1:0] fi_reg;
    logic [SB-1:0] dr_reg;
    logic [SB-1:0] dc_reg;
    logic [CI-1:0] zero_reg;
    logic [CI-1:0] sat_reg;
    logic [CI-1:0] pass_reg;
    logic [CIX-1:0] j_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] quo_reg;
    logic [CI:0]   rem_reg;
    logic [DB-1:0] dcnt_reg;
    logic [7:0]    cells_reg [CELLS];
    logic          out_valid_reg;
    logic [7:0]    out_pix_reg;
    logic          out_last_reg;

    logic [7:0]    cells_next [CELLS];
    logic          capture;
    logic          load_out;
    logic [12:0]   rr;
    logic [10:0]   row_c;
    logic [12:0]   rdelta;
    logic [RB+1:0] rsum;
    logic [RB-1:0] ring_c;
    logic [XW+1:0] cc;
    logic [XW-1:0] col_c;
    logic [XW-1:0] col_max;
    logic [CI-1:0] kept;
    logic [CI+1:0] rank_lo;
    logic [CI+1:0] rank_hi;
    logic [CI+1:0] first_j;
    logic [CI+1:0] last_j;
    logic [CI:0]   den;
    logic [CI:0]   trial;

    // ---- window address: clamp to the frame edge, then map row to ring slot
    always_comb
    begin
        col_max = XW'(w_eff - WW'(1));
        rr = 13'(row_reg) + 13'(dr_reg) - 13'(RADIUS);
        if (rr[12])
        begin
            row_c = 11'd0;
        end
        else if (rr > 13'(h_eff - 11'd1))
        begin
            row_c = h_eff - 11'd1;
        end
        else
        begin
            row_c = rr[10:0];
        end
        rdelta = 13'(row_c) - 13'(row_reg);
        rsum   = (RB + 2)'(ring_reg) + rdelta[RB+1:0];
        if (rsum[RB+1])
        begin
            ring_c = RB'(rsum + (RB + 2)'(RING));
        end
        else if (rsum >= (RB + 2)'(RING))
        begin
            ring_c = RB'(rsum - (RB + 2)'(RING));
        end
        else
        begin
            ring_c = rsum[RB-1:0];
        end
        cc = (XW + 2)'(col_reg) + (XW + 2)'(dc_reg) - (XW + 2)'(RADIUS);
        if (cc[XW+1])
        begin
            col_c = '0;
        end
        else if (cc > (XW + 2)'(col_max))
        begin
            col_c = col_max;
        end
        else
        begin
            col_c = cc[XW-1:0];
        end
    end

    assign ram_raddr = AW'(ring_c) * AW'(MAX_WIDTH) + AW'(col_c);

    // ---- trimmed ranks: zeros sort to the front, whites to the back
    assign kept    = CI'(CELLS) - zero_reg - sat_reg;
    assign rank_lo = (CI + 2)'(kept) >> 2;
    assign rank_hi = ((CI + 2)'(kept) * (CI + 2)'(3)) >> 2;
    assign first_j = (CI + 2)'(zero_reg) + rank_lo;
    assign last_j  = (CI + 2)'(zero_reg) + rank_hi;
    assign den     = (CI + 1)'(rank_hi - rank_lo + (CI + 2)'(1));
    assign trial   = {rem_reg[CI-1:0], quo_reg[SW-1]};

    // one odd-even transposition pass
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        for (int i = 0; i < CELLS - 1; i++)
        begin
            if (((i % 2) == int'(pass_reg[0])) && (cells_reg[i] > cells_reg[i + 1]))
            begin
                cells_next[i]     = cells_reg[i + 1];
                cells_next[i + 1] = cells_reg[i];
            end
        end
    end

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (fi_reg == CI'(CELLS))
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (pass_reg == CI'(CELLS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (j_reg == CIX'(CELLS - 1))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == DB'(SW - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---- control outputs
    always_comb
    begin
        job_pop  = 1'b0;
        ram_re   = 1'b0;
        capture  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                job_pop = job_valid;
            end
            ST_FETCH:
            begin
                ram_re  = fi_reg < CI'(CELLS);
                capture = fi_reg != '0;
            end
            ST_HOLD:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            {last_reg, ring_reg, col_reg, row_reg} <= job_data;
            fi_reg   <= '0;
            dr_reg   <= '0;
            dc_reg   <= '0;
            zero_reg <= '0;
            sat_reg  <= '0;
            pass_reg <= '0;
            j_reg    <= '0;
            sum_reg  <= '0;
            dcnt_reg <= '0;
            rem_reg  <= '0;
        end
        if (state_reg == ST_FETCH)
        begin
            fi_reg <= fi_reg + CI'(1);
            if (ram_re)
            begin
                if (dc_reg == SB'(SPAN - 1))
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + SB'(1);
                end
                else
                begin
                    dc_reg <= dc_reg + SB'(1);
                end
            end
            if (capture)
            begin
                cells_reg[CIX'(fi_reg - CI'(1))] <= ram_rdata;
                zero_reg <= zero_reg + CI'(ram_rdata == PIX_BLACK);
                sat_reg  <= sat_reg + CI'(ram_rdata == PIX_WHITE);
            end
        end
        if (state_reg == ST_SORT)
        begin
            pass_reg <= pass_reg + CI'(1);
            for (int i = 0; i < CELLS; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
        end
        if (state_reg == ST_SUM)
        begin
            j_reg <= j_reg + CIX'(1);
            if (((CI + 2)'(j_reg) >= first_j) && ((CI + 2)'(j_reg) <= last_j))
            begin
                sum_reg <= sum_reg + SW'(cells_reg[j_reg]);
            end
        end
        if ((state_reg == ST_SUM) && (j_reg == CIX'(CELLS - 1)))
        begin
            if (((CI + 2)'(j_reg) >= first_j) && ((CI + 2)'(j_reg) <= last_j))
            begin
                quo_reg <= sum_reg + SW'(cells_reg[j_reg]);
            end
            else
            begin
                quo_reg <= sum_reg;
            end
        end
        // restoring divide, one quotient bit per cycle
        if (state_reg == ST_DIV)
        begin
            dcnt_reg <= dcnt_reg + DB'(1);
            if (trial >= den)
            begin
                rem_reg <= trial - den;
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
        end
        if (load_out)
        begin
            // nothing left after dropping black and white gives 0
            out_pix_reg  <= (kept == '0) ? 8'd0 : quo_reg[7:0];
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_pix_reg;
    assign m_tlast         = out_last_reg;
    assign bstat.busy      = state_reg != ST_IDLE;
    assign bstat.done      = load_out;
    assign bstat.done_last = load_out && last_reg;

endmodule

// ----- rtl/interquartile_mean_image_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interquartile_mean_image_filter
// Streaming 3x3 (or larger) interquartile mean filter with salt/pepper reject.
// ----------------------------------------------------------------------------
// Flow: a job passes fetch of its CELLS = (2*RADIUS+1)^2 window cells, sort,
//   trimmed sum, serial divide and hold; hold waits on a full output register.
// Throughput: items that cause no result go at one per cycle while the queue
//   has room and last_pend is low; the single back end runs one job at once.
// Reset: counters and queue cleared, geometry 256x256; line store not cleared.
// ----------------------------------------------------------------------------
module interquartile_mean_image_filter import iqm_pkg::*; #(
    parameter int RADIUS    = 1,
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tlast
);

    localparam int RING = 3 * RADIUS + 1;
    localparam int RB   = $clog2(RING);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int JW   = 11 + XW + RB + 1;

    logic          acc;
    iqm_bstat_t    bstat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          job_push;
    logic [JW-1:0] job_data;
    logic          job_pop;
    logic [JW-1:0] head_data;
    logic [1:0]    fifo_cnt;
    logic [WW-1:0] w_eff;
    logic [10:0]   h_eff;
    logic          last_pend;

    // at most two jobs in flight keeps the writer clear of live window rows;
    // with one-pixel rows the next pixel already lands in the oldest live row
    assign s_tready = ((fifo_cnt + 2'(bstat.busy)) <
                       ((w_eff == WW'(1)) ? 2'd1 : 2'd2)) && !last_pend;
    assign acc      = s_tvalid && s_tready;

    iqm_front #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .action    (s_tuser),
        .pixel     (s_tdata),
        .bstat     (bstat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_push  (job_push),
        .job_data  (job_data),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .last_pend (last_pend)
    );

    iqm_ram #(
        .WIDTH (8),
        .DEPTH (RING * MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    iqm_fifo #(
        .WIDTH (JW)
    ) u_jobs (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_data),
        .pop       (job_pop),
        .head_data (head_data),
        .count     (fifo_cnt)
    );

    iqm_back #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (fifo_cnt != 2'd0),
        .job_data  (head_data),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .ram_rdata (ram_rdata),
        .m_tready  (m_tready),
        .job_pop   (job_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .bstat     (bstat)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (fifo_cnt != 2'd2))
        else $error("job pushed into full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (fifo_cnt != 2'd0))
        else $error("job popped from empty queue");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("line store written at the address being fetched");

    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.done_last |=> !last_pend)
        else $error("frame end not released after last result");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interquartile mean image filter: directed frames
// from a table, then random frames, mostly small, with noise, checked against an
// in-bench window/IQM predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import iqm_pkg::*;

    localparam int RAD        = 1;
    localparam int MAX_W      = 1024;
    localparam int RING       = 3 * RAD + 1;
    localparam int DRAIN_WAIT = 64;
    localparam int CYCLE_CAP  = 2000000;
    localparam int ITEM_GOAL  = 1100;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } pix_result_t;

    typedef struct {
        bit         cfg;
        logic       addr;
        logic [10:0] val;
        logic       act;
        logic [7:0] pix;
        bit         typed;
        logic [7:0] epix;
        logic       elast;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel_in
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] pixel_out
    logic        m_tlast;

    pix_result_t pending_pixels[$];
    logic [7:0]  ring_rows [0:RING*MAX_W-1];
    logic [10:0] cur_width;
    logic [10:0] cur_height;
    int unsigned frame_pos;
    int unsigned cycle_cnt;
    int unsigned mismatch_cnt;
    int unsigned stim_count;
    int unsigned hold_left;

    interquartile_mean_image_filter #(.RADIUS(RAD), .MAX_WIDTH(MAX_W)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    stim_row_t dir_rows[] = '{
        '{1, REG_WIDTH,  11'd1, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        '{1, REG_HEIGHT, 11'd1, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        // lone white pixel: everything dropped, mean of nothing is 0
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd255, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   1, 8'd0, 1'b1},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   1, 8'd0, 1'b1},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd128, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   1, 8'd128, 1'b1},
        '{1, REG_WIDTH,  11'd2, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        '{1, REG_HEIGHT, 11'd2, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        // early drain is ignored, late pixel behaves as a drain
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd9,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd1,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd255, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd200, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd77,  0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        // zero geometry is taken as 1x1
        '{1, REG_WIDTH,  11'd0, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        '{1, REG_HEIGHT, 11'd0, ACT_PIXEL, 8'd0, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_PIXEL, 8'd254, 0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   0, 8'd0, 1'b0},
        '{0, REG_WIDTH, 11'd0, ACT_DRAIN, 8'd0,   1, 8'd254, 1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (cur_width == 0)
            return 1;
        return (cur_width > MAX_W) ? MAX_W : cur_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cur_height == 0) ? 1 : cur_height;
    endfunction

    function automatic logic [7:0] window_iqm(int row, int col, int w, int h);
        logic [7:0]  kept[$];
        logic [7:0]  v;
        int          r;
        int          c;
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        int unsigned acc;
        for (int dr = -RAD; dr <= RAD; dr++)
        begin
            for (int dc = -RAD; dc <= RAD; dc++)
            begin
                r = row + dr;
                c = col + dc;
                r = (r < 0) ? 0 : ((r > h - 1) ? h - 1 : r);
                c = (c < 0) ? 0 : ((c > w - 1) ? w - 1 : c);
                v = ring_rows[(r % RING) * MAX_W + c];
                if (v != PIX_BLACK && v != PIX_WHITE)
                    kept.push_back(v);
            end
        end
        kept.sort();
        k = kept.size();
        if (k == 0)
            return 8'd0;
        lo = k / 4;
        hi = (3 * k) / 4;
        acc = 0;
        for (int unsigned q = lo; q <= hi; q++)
            acc += kept[q];
        return 8'(acc / (hi - lo + 1));
    endfunction

    // advances the frame state for one accepted transaction
    function automatic void filter_step(logic act, logic [7:0] pix,
                                        output bit hit, output pix_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned lag;
        int unsigned t;
        int unsigned o;
        w = eff_width();
        h = eff_height();
        total = w * h;
        lag = RAD * w + RAD;
        t = frame_pos;
        hit = 0;
        res = '0;
        if (t < total)
        begin
            if (act == ACT_DRAIN)
                return;
            ring_rows[((t / w) % RING) * MAX_W + (t % w)] = pix;
        end
        if (t >= lag && t - lag < total)
        begin
            o = t - lag;
            hit = 1;
            res.pix = window_iqm(o / w, o % w, w, h);
            res.last = (o == total - 1);
            if (res.last)
            begin
                frame_pos = 0;
                return;
            end
        end
        frame_pos = t + 1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if ((cycle_cnt / 700) % 4 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return PIX_BLACK;
        if (r < 24)
            return PIX_WHITE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_WIDTH)
            cur_width = val;
        else
            cur_height = val;
        frame_pos = 0;
    endtask

    task automatic send_item(logic act, logic [7:0] pix, bit typed = 0,
                             pix_result_t typed_res = '0);
        int unsigned gap;
        bit          hit;
        pix_result_t res;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        filter_step(act, pix, hit, res);
        if (hit)
            pending_pixels.push_back(typed ? typed_res : res);
    endtask

    task automatic run_frame(int unsigned fidx);
        logic [10:0] wv;
        logic [10:0] hv;
        int unsigned w;
        int unsigned total;
        int unsigned lag;
        int unsigned n;
        case (fidx)
            3:       begin wv = 11'd1;    hv = 11'd300;  end
            7:       begin wv = 11'd300;  hv = 11'd1;    end
            11:      begin wv = 11'd0;    hv = 11'd0;    end
            default: begin wv = 11'($urandom_range(1, 7)); hv = 11'($urandom_range(1, 6)); end
        endcase
        wait_idle();
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
        w = eff_width();
        total = w * eff_height();
        lag = RAD * w + RAD;
        // abandoned frame: no more pixels than the lag, so nothing is pending
        if ($urandom_range(0, 99) < 8)
        begin
            n = $urandom_range(1, (total < lag) ? total : lag);
            repeat (n)
            begin
                send_item(ACT_PIXEL, pick_pixel());
                stim_count++;
            end
            wait_idle();
            write_reg(REG_WIDTH, wv);
        end
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
                stim_count++;
            end
            send_item(ACT_PIXEL, pick_pixel());
            stim_count++;
        end
        // tail: both kinds act as a flush once the frame is complete
        for (int unsigned i = 0; i < lag; i++)
        begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            stim_count++;
        end
    endtask

    initial
    begin
        pix_result_t typed_res;
        int unsigned fidx;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_WIDTH;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_PIXEL;
        cur_width  = 11'd256;
        cur_height = 11'd256;
        frame_pos  = 0;
        stim_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
            begin
                wait_idle();
                write_reg(dir_rows[i].addr, dir_rows[i].val);
            end
            else
            begin
                typed_res.pix  = dir_rows[i].epix;
                typed_res.last = dir_rows[i].elast;
                send_item(dir_rows[i].act, dir_rows[i].pix, dir_rows[i].typed, typed_res);
                stim_count++;
            end
        end
        fidx = 0;
        while (stim_count < ITEM_GOAL)
        begin
            run_frame(fidx);
            fidx++;
        end
        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASS interquartile_mean_image_filter");
        else
            $display("FAIL interquartile_mean_image_filter");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        int unsigned stall_left;
        int unsigned r;
        pix_result_t want;
        m_tready     = 1'b0;
        mismatch_cnt = 0;
        stall_left   = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected transaction: pix=%0d last=%0b", m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (m_tdata !== want.pix || m_tlast !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: pix exp %0d got %0d, last exp %0b got %0b",
                                     want.pix, m_tdata, want.last, m_tlast);
                    end
                end
            end
            if (cycle_cnt == 4000)
                hold_left = 2500;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ((cycle_cnt / 900) % 4 == 1)
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 100);
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL interquartile_mean_image_filter");
        $finish;
    end

endmodule
